>>> rtl/trsc_pkg.sv
// Shared widths, types and pipeline structures for the triangle row span calculator.
// Used by every module of the block; depends on nothing.
package trsc_pkg;

    localparam int COORD_BITS = 10;
    localparam int OFF_BITS   = 10;
    localparam int COLOR_BITS = 32;
    localparam int SPAN_BITS  = 10;

    // Magnitude of edge delta times row count, and one divider stage per quotient bit.
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int DIV_STAGES = COORD_BITS;

    // Widths used to compare and add coordinates against the row offset.
    localparam int EXT_BITS  = (COORD_BITS > SPAN_BITS) ? COORD_BITS : SPAN_BITS;
    localparam int WIDE_BITS = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vtx_t;

    // One edge division in flight: partial remainder, shifted divisor, quotient so far.
    typedef struct packed {
        logic [PROD_BITS-1:0] rem;
        logic [PROD_BITS-1:0] dsh;
        coord_t               quo;
    } div_lane_t;

    // Fields that ride along with the divisions.
    typedef struct packed {
        logic                  span_ok;
        logic [SPAN_BITS-1:0]  row_y;
        logic [COLOR_BITS-1:0] color;
        coord_t                base_a;
        coord_t                base_b;
        logic                  neg_a;
        logic                  neg_b;
    } side_t;

    typedef struct packed {
        side_t     side;
        div_lane_t lane_a;
        div_lane_t lane_b;
    } div_stage_t;

endpackage

>>> rtl/triangle_row_span_calculator_unit.sv
// Top level of the triangle row span calculator: setup, divider chain, output stage.
// Depends on trsc_pkg, trsc_setup and trsc_div_step.
//
// Usage: the input channel (in_valid, in_stall) carries one triangle's three
// vertices, a row offset counted from the top vertex and a fill color. The
// output channel (out_valid, out_stall) returns one span per input transfer,
// in order: span_valid, row_y, span_left..span_right inclusive and the color.
// When the row lies outside the triangle or the triangle is flat, span_valid
// is 0 and row_y, span_left and span_right are 0.
// Throughput: one transfer per cycle while out_stall does not hold the output.
// From the input transfer to out_valid a span passes, register by register,
// the sort stage (loaded at the transfer edge itself), the multiply stage,
// one divider stage per quotient bit and the output stage.
// The whole pipeline moves on one advance signal: when the output holds a
// span and out_stall is high, every stage holds and in_stall is raised in the
// same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the block can take a transfer as soon as
// reset is released.
module triangle_row_span_calculator_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v0_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v0_y,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v1_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v1_y,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v2_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v2_y,
    input  logic [trsc_pkg::OFF_BITS-1:0]       row_offset,
    input  logic [trsc_pkg::COLOR_BITS-1:0]     fill_color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                span_valid,
    output logic [trsc_pkg::SPAN_BITS-1:0]      row_y,
    output logic [trsc_pkg::SPAN_BITS-1:0]      span_left,
    output logic [trsc_pkg::SPAN_BITS-1:0]      span_right,
    output logic [trsc_pkg::COLOR_BITS-1:0]     span_color
);

    localparam int CB = trsc_pkg::COORD_BITS;
    localparam int NS = trsc_pkg::DIV_STAGES;
    localparam int SB = trsc_pkg::SPAN_BITS;
    localparam int EB = trsc_pkg::EXT_BITS;

    logic                 adv;
    logic                 vld [0:NS];
    trsc_pkg::div_stage_t st  [0:NS];

    trsc_pkg::side_t      sd;
    logic [CB+1:0]        ext_a, ext_b, sum_a, sum_b;
    trsc_pkg::coord_t     xa, xb, lo, hi;

    logic                  out_valid_reg;
    logic                  span_valid_reg, span_valid_next;
    logic [SB-1:0]         row_y_reg, row_y_next;
    logic [SB-1:0]         span_left_reg, span_left_next;
    logic [SB-1:0]         span_right_reg, span_right_next;
    logic [trsc_pkg::COLOR_BITS-1:0] span_color_reg;

    // The pipeline advances unless a finished span is held by the receiver.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    trsc_setup u_setup
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .row_offset (row_offset),
        .fill_color (fill_color),
        .out_valid  (vld[0]),
        .out_stage  (st[0])
    );

    // One divider stage per quotient bit.
    for (genvar g = 0; g < NS; g++)
    begin : g_div
        trsc_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (vld[g]),
            .in_stage  (st[g]),
            .out_valid (vld[g+1]),
            .out_stage (st[g+1])
        );
    end

    // Apply the signs, add the bases and order both edges.
    always_comb
    begin
        sd    = st[NS].side;
        ext_a = {2'b00, st[NS].lane_a.quo};
        ext_b = {2'b00, st[NS].lane_b.quo};
        sum_a = {2'b00, sd.base_a} + (sd.neg_a ? -ext_a : ext_a);
        sum_b = {2'b00, sd.base_b} + (sd.neg_b ? -ext_b : ext_b);
        xa    = sum_a[CB-1:0];
        xb    = sum_b[CB-1:0];
        lo    = (xa < xb) ? xa : xb;
        hi    = (xa < xb) ? xb : xa;

        span_valid_next = sd.span_ok;
        row_y_next      = sd.span_ok ? sd.row_y : '0;
        span_left_next  = sd.span_ok ? SB'(EB'(lo)) : '0;
        span_right_next = sd.span_ok ? SB'(EB'(hi)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            span_valid_reg <= span_valid_next;
            row_y_reg      <= row_y_next;
            span_left_reg  <= span_left_next;
            span_right_reg <= span_right_next;
            span_color_reg <= sd.color;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_valid = span_valid_reg;
    assign row_y      = row_y_reg;
    assign span_left  = span_left_reg;
    assign span_right = span_right_reg;
    assign span_color = span_color_reg;

endmodule

>>> rtl/trsc_setup.sv
// Front end: vertex sort, half selection and edge products (two register stages).
// Depends on trsc_pkg.
module trsc_setup
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v0_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v0_y,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v1_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v1_y,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v2_x,
    input  logic [trsc_pkg::COORD_BITS-1:0]     v2_y,
    input  logic [trsc_pkg::OFF_BITS-1:0]       row_offset,
    input  logic [trsc_pkg::COLOR_BITS-1:0]     fill_color,
    output logic                                out_valid,
    output trsc_pkg::div_stage_t                out_stage
);

    localparam int CB = trsc_pkg::COORD_BITS;
    localparam int WB = trsc_pkg::WIDE_BITS;
    localparam int PB = trsc_pkg::PROD_BITS;

    typedef struct packed {
        trsc_pkg::side_t  side;
        trsc_pkg::coord_t mag_a;
        trsc_pkg::coord_t num_a;
        trsc_pkg::coord_t den_a;
        trsc_pkg::coord_t mag_b;
        trsc_pkg::coord_t num_b;
        trsc_pkg::coord_t den_b;
    } setup_t;

    trsc_pkg::vtx_t       p0, p1, p2, tmp;
    trsc_pkg::coord_t     total, upper;
    logic [WB-1:0]        off_w;
    logic                 flat, lower;
    logic [CB:0]          da, db;
    setup_t               s1_next, s1_reg;
    logic                 v1_reg;
    trsc_pkg::div_stage_t s2_next, s2_reg;
    logic                 v2_reg;

    // Sort by y with three compare-swaps, then pick the half and the edge terms.
    always_comb
    begin
        p0 = '{x: v0_x, y: v0_y};
        p1 = '{x: v1_x, y: v1_y};
        p2 = '{x: v2_x, y: v2_y};
        tmp = p0;
        flat = (v0_y == v1_y) && (v0_y == v2_y);
        if (p0.y > p1.y)
        begin
            tmp = p0; p0 = p1; p1 = tmp;
        end
        if (p0.y > p2.y)
        begin
            tmp = p0; p0 = p2; p2 = tmp;
        end
        if (p1.y > p2.y)
        begin
            tmp = p1; p1 = p2; p2 = tmp;
        end
        total = p2.y - p0.y;
        upper = p1.y - p0.y;
        off_w = WB'(row_offset);
        lower = (off_w > WB'(upper)) || (upper == '0);

        s1_next.side.span_ok = !flat && (off_w < WB'(total));
        s1_next.side.row_y   = trsc_pkg::SPAN_BITS'(WB'(p0.y) + off_w);
        s1_next.side.color   = fill_color;

        // Long edge from top to bottom vertex.
        da = {1'b0, p2.x} - {1'b0, p0.x};
        s1_next.side.base_a = p0.x;
        s1_next.side.neg_a  = da[CB];
        s1_next.mag_a       = CB'(da[CB] ? -da : da);
        s1_next.num_a       = CB'(off_w);
        s1_next.den_a       = total;

        // Short edge of the selected half.
        if (lower)
        begin
            db = {1'b0, p2.x} - {1'b0, p1.x};
            s1_next.side.base_b = p1.x;
            s1_next.num_b       = CB'(off_w - WB'(upper));
            s1_next.den_b       = p2.y - p1.y;
        end
        else
        begin
            db = {1'b0, p1.x} - {1'b0, p0.x};
            s1_next.side.base_b = p0.x;
            s1_next.num_b       = CB'(off_w);
            s1_next.den_b       = upper;
        end
        s1_next.side.neg_b = db[CB];
        s1_next.mag_b      = CB'(db[CB] ? -db : db);
    end

    // Products and divisor alignment for the divider stages.
    always_comb
    begin
        s2_next.side       = s1_reg.side;
        s2_next.lane_a.rem = PB'(s1_reg.mag_a) * PB'(s1_reg.num_a);
        s2_next.lane_a.dsh = PB'(s1_reg.den_a) << (CB - 1);
        s2_next.lane_a.quo = '0;
        s2_next.lane_b.rem = PB'(s1_reg.mag_b) * PB'(s1_reg.num_b);
        s2_next.lane_b.dsh = PB'(s1_reg.den_b) << (CB - 1);
        s2_next.lane_b.quo = '0;
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_stage = s2_reg;

endmodule

>>> rtl/trsc_div_step.sv
// One registered restoring-division step for both edge divisions.
// Depends on trsc_pkg.
module trsc_div_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  trsc_pkg::div_stage_t in_stage,
    output logic                 out_valid,
    output trsc_pkg::div_stage_t out_stage
);

    localparam int CB = trsc_pkg::COORD_BITS;

    trsc_pkg::div_stage_t stage_next, stage_reg;
    logic                 valid_reg;

    function automatic trsc_pkg::div_lane_t step_lane(trsc_pkg::div_lane_t ln);
        trsc_pkg::div_lane_t r;
        r = ln;
        if (ln.rem >= ln.dsh)
        begin
            r.rem = ln.rem - ln.dsh;
            r.quo = {ln.quo[CB-2:0], 1'b1};
        end
        else
        begin
            r.quo = {ln.quo[CB-2:0], 1'b0};
        end
        r.dsh = ln.dsh >> 1;
        return r;
    endfunction

    // Take one quotient bit in each lane.
    always_comb
    begin
        stage_next.side   = in_stage.side;
        stage_next.lane_a = step_lane(in_stage.lane_a);
        stage_next.lane_b = step_lane(in_stage.lane_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

>>> rtl/trsc_checker.sv
// Port-level checks for the triangle row span calculator, bound to the top level.
// Depends on trsc_pkg and triangle_row_span_calculator_unit.
module trsc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                span_valid,
    input  logic [trsc_pkg::SPAN_BITS-1:0]      row_y,
    input  logic [trsc_pkg::SPAN_BITS-1:0]      span_left,
    input  logic [trsc_pkg::SPAN_BITS-1:0]      span_right,
    input  logic [trsc_pkg::COLOR_BITS-1:0]     span_color
);

    // A held span keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(span_left) && $stable(span_right)
            && $stable(row_y) && $stable(span_color) && $stable(span_valid))
        else $error("held span changed");

    // Input backpressure comes only from a held output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    // An empty row carries zero coordinates.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> row_y == '0 && span_left == '0 && span_right == '0)
        else $error("empty row with nonzero fields");

    // Span bounds are ordered.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_valid |-> span_left <= span_right)
        else $error("span left beyond right");

endmodule

bind triangle_row_span_calculator_unit trsc_checker u_trsc_checker (.*);
